/* design/brb_pkg.sv */
package brb_pkg;

  localparam int DEPTH   = 4096;
  localparam int MAX_RUN = 64;
  localparam int QDEPTH  = 4;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SUM_W  = IDX_W + 1;
  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int REQ_W  = 3;
  localparam int LEN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 12;
  localparam int SPAN_W = 13;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_SKIP  = 3'd3,
    REQ_ADV   = 3'd4,
    REQ_CLEAR = 3'd5
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_NO_DATA  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE,
    BK_BURST
  } back_state_e;

  // one queued job: either a single result or a read burst
  typedef struct packed {
    logic                is_read;
    status_e             status;
    logic [IDX_W-1:0]    start;
    logic [RUN_W-1:0]    len;
    logic [IDX_W-1:0]    rd;
    logic [IDX_W-1:0]    wr;
  } job_t;

  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                               input logic [LEN_W-1:0] len);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(len);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return IDX_W'(sum);
  endfunction

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] used_of(input logic [IDX_W-1:0] rd,
                                               input logic [IDX_W-1:0] wr);
    logic [SUM_W-1:0] u;
    if (wr >= rd) begin
      u = SUM_W'(wr) - SUM_W'(rd);
    end else begin
      u = SUM_W'(wr) + SUM_W'(DEPTH) - SUM_W'(rd);
    end
    return IDX_W'(u);
  endfunction

  function automatic logic [IDX_W-1:0] free_of(input logic [IDX_W-1:0] rd,
                                               input logic [IDX_W-1:0] wr);
    return IDX_W'(DEPTH - 1) - used_of(rd, wr);
  endfunction

  function automatic logic [SPAN_W-1:0] wspan_of(input logic [IDX_W-1:0] rd,
                                                 input logic [IDX_W-1:0] wr);
    logic [SPAN_W-1:0] s;
    if (wr >= rd) begin
      if (rd == '0) begin
        s = SPAN_W'(DEPTH - 1) - SPAN_W'(wr);
      end else begin
        s = SPAN_W'(DEPTH) - SPAN_W'(wr);
      end
    end else begin
      s = SPAN_W'(rd) - SPAN_W'(wr) - SPAN_W'(1);
    end
    return s;
  endfunction

  function automatic logic [SPAN_W-1:0] rspan_of(input logic [IDX_W-1:0] rd,
                                                 input logic [IDX_W-1:0] wr);
    logic [SPAN_W-1:0] s;
    if (rd <= wr) begin
      s = SPAN_W'(wr) - SPAN_W'(rd);
    end else begin
      s = SPAN_W'(DEPTH) - SPAN_W'(rd);
    end
    return s;
  endfunction

endpackage

/* design/byte_ring_buffer_top.sv */
// Circular byte store with one slot kept empty. An item is taken when start
// is high and busy is low; each result word shows for one cycle with
// strobe_o high and cannot be held off. Each item passes through the job
// queue and the registered outputs of the back end before its first result
// word is on the ports. Items with a single result go at one per cycle while
// busy stays low. A pop or peek of n bytes streams n results, one per cycle,
// out of the single read port of the byte store; busy stays high from that
// item until its last byte is fetched, and only then is the next item taken.
// busy also rises when the four-entry job queue is full.
module byte_ring_buffer_top
  import brb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              first_of_run_i,
  output logic              strobe_o,
  output logic [STAT_W-1:0] status_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_o,
  output logic [CNT_W-1:0]  used_count_o,
  output logic [CNT_W-1:0]  free_count_o,
  output logic [SPAN_W-1:0] contiguous_write_span_o,
  output logic [SPAN_W-1:0] contiguous_read_span_o
);

  job_t              fe_job, q_job;
  logic              fe_push, q_full, q_valid, bk_pop, rd_done;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  brb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .length_i       (length_i),
    .data_byte_i    (data_byte_i),
    .first_of_run_i (first_of_run_i),
    .q_full_i       (q_full),
    .rd_done_i      (rd_done),
    .job_push_o     (fe_push),
    .job_o          (fe_job),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata)
  );

  brb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .job_i   (fe_job),
    .pop_i   (bk_pop),
    .job_o   (q_job),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  brb_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  brb_back u_back (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .job_i                   (q_job),
    .job_valid_i             (q_valid),
    .job_pop_o               (bk_pop),
    .rd_done_o               (rd_done),
    .ram_raddr_o             (ram_raddr),
    .ram_rdata_i             (ram_rdata),
    .strobe_o                (strobe_o),
    .status_o                (status_o),
    .out_byte_o              (out_byte_o),
    .last_o                  (last_o),
    .used_count_o            (used_count_o),
    .free_count_o            (free_count_o),
    .contiguous_write_span_o (contiguous_write_span_o),
    .contiguous_read_span_o  (contiguous_read_span_o)
  );

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o != ST_OK) |-> last_o)
    else $error("error result not marked last");

  a_byte_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (out_byte_o != '0) |-> (status_o == ST_OK))
    else $error("data byte on an error result");

  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> ((SUM_W'(used_count_o) + SUM_W'(free_count_o)) == SUM_W'(DEPTH - 1)))
    else $error("used and free counts disagree");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_pop |-> q_valid)
    else $error("job queue popped while empty");
`endif

endmodule

/* design/brb_ram.sv */
module brb_ram
  import brb_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/brb_queue.sv */
module brb_queue
  import brb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic valid_o,
  output logic full_o
);

  job_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] head_q, tail_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign job_o   = slot_q[head_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[tail_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        tail_q <= ptr_inc(tail_q);
      end
      if (pop_i) begin
        head_q <= ptr_inc(head_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

/* design/brb_front.sv */
module brb_front
  import brb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              first_of_run_i,
  input  logic              q_full_i,
  input  logic              rd_done_i,
  output logic              job_push_o,
  output job_t              job_o,
  output logic              ram_we_o,
  output logic [IDX_W-1:0]  ram_waddr_o,
  output logic [BYTE_W-1:0] ram_wdata_o
);

  logic [IDX_W-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic             rej_q, rej_d;
  logic             pend_q, pend_d;
  logic             accept;
  logic [IDX_W-1:0] used, free;
  status_e          status;
  logic             is_read;

  // a read burst holds the port until its last byte is fetched, so later
  // writes never land on bytes still waiting to be read
  assign busy   = q_full_i || pend_q;
  assign accept = start && !busy;
  assign used   = used_of(rd_q, wr_q);
  assign free   = free_of(rd_q, wr_q);

  assign ram_waddr_o = wr_q;
  assign ram_wdata_o = data_byte_i;

  always_comb begin
    rd_d     = rd_q;
    wr_d     = wr_q;
    left_d   = left_q;
    rej_d    = rej_q;
    status   = ST_OK;
    is_read  = 1'b0;
    ram_we_o = 1'b0;
    unique case (req_e'(req_type_i))
      REQ_PUSH: begin
        if (first_of_run_i) begin
          if (SUM_W'(length_i) > SUM_W'(free)) begin
            rej_d  = 1'b1;
            left_d = '0;
            status = ST_NO_SPACE;
          end else begin
            rej_d = 1'b0;
            if (length_i != '0) begin
              ram_we_o = 1'b1;
              wr_d     = idx_inc(wr_q);
              left_d   = length_i - LEN_W'(1);
            end else begin
              left_d = '0;
            end
          end
        end else if (rej_q) begin
          status = ST_NO_SPACE;
        end else if (left_q == '0) begin
          status = ST_TOO_LONG;
        end else begin
          ram_we_o = 1'b1;
          wr_d     = idx_inc(wr_q);
          left_d   = left_q - LEN_W'(1);
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (SUM_W'(length_i) > SUM_W'(MAX_RUN)) begin
          status = ST_TOO_LONG;
        end else if (SUM_W'(length_i) > SUM_W'(used)) begin
          status = ST_NO_DATA;
        end else if (length_i != '0) begin
          is_read = 1'b1;
          if (req_e'(req_type_i) == REQ_POP) begin
            rd_d = idx_add(rd_q, length_i);
          end
        end
      end
      REQ_SKIP: rd_d = idx_add(rd_q, length_i);
      REQ_ADV:  wr_d = idx_add(wr_q, length_i);
      REQ_CLEAR: begin
        rd_d = '0;
        wr_d = '0;
      end
      default: ;
    endcase

    if (!accept) begin
      ram_we_o = 1'b0;
    end

    pend_d = pend_q;
    if (rd_done_i) begin
      pend_d = 1'b0;
    end
    if (accept && is_read) begin
      pend_d = 1'b1;
    end

    job_o.is_read = is_read;
    job_o.status  = status;
    job_o.start   = rd_q;
    job_o.len     = RUN_W'(length_i);
    job_o.rd      = rd_d;
    job_o.wr      = wr_d;
    job_push_o    = accept;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      wr_q   <= '0;
      left_q <= '0;
      rej_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_q   <= rd_d;
        wr_q   <= wr_d;
        left_q <= left_d;
        rej_q  <= rej_d;
      end
      pend_q <= pend_d;
    end
  end

endmodule

/* design/brb_back.sv */
module brb_back
  import brb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  job_t              job_i,
  input  logic              job_valid_i,
  output logic              job_pop_o,
  output logic              rd_done_o,
  output logic [IDX_W-1:0]  ram_raddr_o,
  input  logic [BYTE_W-1:0] ram_rdata_i,
  output logic              strobe_o,
  output logic [STAT_W-1:0] status_o,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              last_o,
  output logic [CNT_W-1:0]  used_count_o,
  output logic [CNT_W-1:0]  free_count_o,
  output logic [SPAN_W-1:0] contiguous_write_span_o,
  output logic [SPAN_W-1:0] contiguous_read_span_o
);

  back_state_e      state_q, state_d;
  job_t             job_q, job_d, cur;
  logic [RUN_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic             emit, beat, last;
  status_e          status;

  logic              strobe_q, sel_q, last_q;
  status_e           status_q;
  logic [CNT_W-1:0]  used_q, free_q;
  logic [SPAN_W-1:0] wspan_q, rspan_q;

  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    cnt_d       = cnt_q;
    addr_d      = addr_q;
    cur         = job_q;
    job_pop_o   = 1'b0;
    rd_done_o   = 1'b0;
    emit        = 1'b0;
    beat        = 1'b0;
    last        = 1'b0;
    status      = ST_OK;
    ram_raddr_o = addr_q;
    unique case (state_q)
      BK_IDLE: begin
        cur = job_i;
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          emit      = 1'b1;
          if (job_i.is_read) begin
            beat        = 1'b1;
            ram_raddr_o = job_i.start;
            job_d       = job_i;
            addr_d      = idx_inc(job_i.start);
            cnt_d       = RUN_W'(1);
            if (job_i.len == RUN_W'(1)) begin
              last      = 1'b1;
              rd_done_o = 1'b1;
            end else begin
              state_d = BK_BURST;
            end
          end else begin
            last   = 1'b1;
            status = job_i.status;
          end
        end
      end
      BK_BURST: begin
        emit   = 1'b1;
        beat   = 1'b1;
        addr_d = idx_inc(addr_q);
        cnt_d  = cnt_q + RUN_W'(1);
        if (cnt_q == job_q.len - RUN_W'(1)) begin
          last      = 1'b1;
          rd_done_o = 1'b1;
          state_d   = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      strobe_q <= 1'b0;
      sel_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= emit;
      sel_q    <= beat;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    cnt_q    <= cnt_d;
    addr_q   <= addr_d;
    status_q <= status;
    last_q   <= last;
    used_q   <= CNT_W'(used_of(cur.rd, cur.wr));
    free_q   <= CNT_W'(free_of(cur.rd, cur.wr));
    wspan_q  <= wspan_of(cur.rd, cur.wr);
    rspan_q  <= rspan_of(cur.rd, cur.wr);
  end

  assign strobe_o                = strobe_q;
  assign status_o                = status_q;
  assign out_byte_o              = sel_q ? ram_rdata_i : '0;
  assign last_o                  = last_q;
  assign used_count_o            = used_q;
  assign free_count_o            = free_q;
  assign contiguous_write_span_o = wspan_q;
  assign contiguous_read_span_o  = rspan_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import brb_pkg::*;

  // request codes the block leaves unused
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  localparam int LEN_MAX        = (1 << LEN_W) - 1;
  localparam int RANDOM_ITEMS   = 480;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [REQ_W-1:0]  req_type_i;
  logic [LEN_W-1:0]  length_i;
  logic [BYTE_W-1:0] data_byte_i;
  logic              first_of_run_i;
  logic              strobe_o;
  logic [STAT_W-1:0] status_o;
  logic [BYTE_W-1:0] out_byte_o;
  logic              last_o;
  logic [CNT_W-1:0]  used_count_o;
  logic [CNT_W-1:0]  free_count_o;
  logic [SPAN_W-1:0] contiguous_write_span_o;
  logic [SPAN_W-1:0] contiguous_read_span_o;

  byte_ring_buffer_top u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .start                  (start),
    .busy                   (busy),
    .req_type_i             (req_type_i),
    .length_i               (length_i),
    .data_byte_i            (data_byte_i),
    .first_of_run_i         (first_of_run_i),
    .strobe_o               (strobe_o),
    .status_o               (status_o),
    .out_byte_o             (out_byte_o),
    .last_o                 (last_o),
    .used_count_o           (used_count_o),
    .free_count_o           (free_count_o),
    .contiguous_write_span_o(contiguous_write_span_o),
    .contiguous_read_span_o (contiguous_read_span_o)
  );

  always #1 clk_i = ~clk_i;

  typedef struct {
    status_e           status;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [CNT_W-1:0]  used_cnt;
    logic [CNT_W-1:0]  free_cnt;
    logic [SPAN_W-1:0] wspan;
    logic [SPAN_W-1:0] rspan;
  } fifo_word_t;

  fifo_word_t expected_words[$];

  // shadow copy of the byte store and its indices
  logic [BYTE_W-1:0] fifo_mem [DEPTH];
  bit                mem_written [DEPTH];
  int                rd_idx;
  int                wr_idx;
  logic              run_rejected;
  int                run_left;

  int  fail_count;
  int  results_checked;
  int  status_seen [4];
  int  op_count [8];
  int  stall_cycles;
  bit  no_idle;

  function automatic int used_now();
    return (wr_idx + DEPTH - rd_idx) % DEPTH;
  endfunction

  function automatic int free_now();
    return DEPTH - used_now() - 1;
  endfunction

  function automatic int wspan_now();
    if (wr_idx >= rd_idx) begin
      return (rd_idx == 0) ? DEPTH - wr_idx - 1 : DEPTH - wr_idx;
    end
    return rd_idx - wr_idx - 1;
  endfunction

  function automatic int rspan_now();
    return (rd_idx <= wr_idx) ? wr_idx - rd_idx : DEPTH - rd_idx;
  endfunction

  task automatic add_expected(input status_e st, input logic [BYTE_W-1:0] b,
                              input logic lst);
    fifo_word_t w;
    w.status   = st;
    w.data     = b;
    w.last     = lst;
    w.used_cnt = CNT_W'(used_now());
    w.free_cnt = CNT_W'(free_now());
    w.wspan    = SPAN_W'(wspan_now());
    w.rspan    = SPAN_W'(rspan_now());
    expected_words.push_back(w);
  endtask

  // advance the shadow fifo by one accepted word and queue its results
  task automatic predict_word(input logic [REQ_W-1:0] req, input logic [LEN_W-1:0] len,
                              input logic [BYTE_W-1:0] data, input logic first_flag);
    status_e st;
    int      n_read;
    int      base;
    st     = ST_OK;
    n_read = 0;
    base   = rd_idx;
    case (req)
      REQ_PUSH: begin
        if (first_flag) begin
          if (len > free_now()) begin
            run_rejected = 1'b1;
            run_left     = 0;
            st           = ST_NO_SPACE;
          end else begin
            run_rejected = 1'b0;
            run_left     = len;
          end
        end else if (run_rejected) begin
          st = ST_NO_SPACE;
        end
        if (st == ST_OK) begin
          if (run_left == 0) begin
            if (!first_flag) st = ST_TOO_LONG;
          end else begin
            fifo_mem[wr_idx]    = data;
            mem_written[wr_idx] = 1'b1;
            wr_idx              = (wr_idx + 1) % DEPTH;
            run_left--;
          end
        end
      end
      REQ_POP, REQ_PEEK: begin
        if (len > MAX_RUN) begin
          st = ST_TOO_LONG;
        end else if (len > used_now()) begin
          st = ST_NO_DATA;
        end else begin
          n_read = len;
          if (req == REQ_POP) rd_idx = (rd_idx + len) % DEPTH;
        end
      end
      REQ_SKIP:  rd_idx = (rd_idx + len) % DEPTH;
      REQ_ADV:   wr_idx = (wr_idx + len) % DEPTH;
      REQ_CLEAR: begin
        rd_idx = 0;
        wr_idx = 0;
      end
      default: ;
    endcase
    if (n_read == 0) add_expected(st, '0, 1'b1);
    for (int i = 0; i < n_read; i++) begin
      add_expected(ST_OK, fifo_mem[(base + i) % DEPTH], i == n_read - 1);
    end
  endtask

  // a read that would pass its checks is cut back so it never touches an
  // entry nothing was pushed into
  function automatic int safe_read_len(input int len);
    int k;
    if (len == 0 || len > MAX_RUN || len > used_now()) return len;
    k = 0;
    while (k < len && mem_written[(rd_idx + k) % DEPTH]) k++;
    return k;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_word(input logic [REQ_W-1:0] req, input logic [LEN_W-1:0] len,
                           input logic [BYTE_W-1:0] data, input logic first_flag);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start          <= 1'b1;
    req_type_i     <= req;
    length_i       <= len;
    data_byte_i    <= data;
    first_of_run_i <= first_flag;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_word(req, len, data, first_flag);
    op_count[req]++;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    fifo_word_t want;
    if (rst_ni && strobe_o) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing predicted (status %0d)", status_o);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("status", want.status, status_o);
        check_field("out_byte", want.data, out_byte_o);
        check_field("last", want.last, last_o);
        check_field("used_count", want.used_cnt, used_count_o);
        check_field("free_count", want.free_cnt, free_count_o);
        check_field("contiguous_write_span", want.wspan, contiguous_write_span_o);
        check_field("contiguous_read_span", want.rspan, contiguous_read_span_o);
        results_checked++;
        status_seen[want.status]++;
      end
    end
  end

  // counts cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  task automatic test_push_runs();
    send_word(REQ_PUSH, '0, 8'h5A, 1'b0);        // no run open yet: dropped
    send_word(REQ_PUSH, '0, 8'h11, 1'b1);        // empty run
    send_word(REQ_PUSH, LEN_W'(3), 8'h00, 1'b1);
    send_word(REQ_PUSH, LEN_W'(LEN_MAX), 8'hFF, 1'b0);
    send_word(REQ_PUSH, '0, 8'hA5, 1'b0);
    send_word(REQ_PUSH, '0, 8'h3C, 1'b0);        // past the end of the run
  endtask

  task automatic test_pop_peek();
    send_word(REQ_PEEK, LEN_W'(3), '0, 1'b0);
    send_word(REQ_POP, LEN_W'(MAX_RUN + 1), '0, 1'b0);
    send_word(REQ_POP, LEN_W'(4), '0, 1'b1);
    send_word(REQ_POP, '0, '0, 1'b0);
    send_word(REQ_POP, LEN_W'(2), '0, 1'b0);
    send_word(REQ_PEEK, LEN_W'(1), '0, 1'b0);
  endtask

  task automatic test_space_check();
    send_word(REQ_PUSH, LEN_W'(LEN_MAX), 8'h77, 1'b1);
    send_word(REQ_PUSH, '0, 8'h78, 1'b0);        // rest of a rejected run
  endtask

  task automatic test_unused_codes();
    send_word(REQ_UNUSED_LO, LEN_W'(LEN_MAX), 8'hFF, 1'b1);
    send_word(REQ_UNUSED_HI, '0, '0, 1'b0);
  endtask

  task automatic test_index_moves();
    send_word(REQ_CLEAR, '0, '0, 1'b0);
    send_word(REQ_ADV, LEN_W'(LEN_MAX), '0, 1'b0);   // store reads as full
    send_word(REQ_SKIP, LEN_W'(LEN_MAX), '0, 1'b0);  // empty at the last slot
    send_word(REQ_PUSH, LEN_W'(4), 8'hC3, 1'b1);     // run wraps the end
    send_word(REQ_PUSH, '0, 8'h96, 1'b0);
    send_word(REQ_PUSH, '0, 8'h69, 1'b0);
    send_word(REQ_PUSH, '0, 8'h0F, 1'b0);
    send_word(REQ_POP, LEN_W'(4), '0, 1'b0);
    send_word(REQ_CLEAR, LEN_W'(LEN_MAX), 8'hFF, 1'b1);
  endtask

  function automatic int pick_run_len();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 70) return $urandom_range(1, 12);
    if (r < 88) begin
      n = free_now() - 1 + int'($urandom_range(0, 2));   // right at the space limit
      if (n < 0) n = 0;
      return (n > LEN_MAX) ? LEN_MAX : n;
    end
    return $urandom_range(0, LEN_MAX);
  endfunction

  function automatic int pick_read_len();
    int r;
    int u;
    u = used_now();
    r = $urandom_range(0, 99);
    if (r < 70) return (u == 0) ? 0 : $urandom_range(1, (u < MAX_RUN) ? u : MAX_RUN);
    if (r < 78) return 0;
    if (r < 88) return (u < MAX_RUN) ? u + 1 : MAX_RUN + 1;
    if (r < 95) return $urandom_range(MAX_RUN + 1, LEN_MAX);
    return MAX_RUN;
  endfunction

  task automatic test_random_traffic();
    int               sent;
    int               pick;
    int               run_len;
    int               n_follow;
    int               amount;
    int               len;
    logic [REQ_W-1:0] req;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        run_len  = pick_run_len();
        n_follow = (run_len > 0) ? run_len - 1 : 0;
        if (n_follow > 24) n_follow = 24;
        case ($urandom_range(0, 9))
          0: n_follow = $urandom_range(0, n_follow);   // run cut short
          1: n_follow = n_follow + 1;                  // one byte too many
          default: ;
        endcase
        send_word(REQ_PUSH, LEN_W'(run_len), BYTE_W'($urandom), 1'b1);
        repeat (n_follow) begin
          send_word(REQ_PUSH, LEN_W'($urandom), BYTE_W'($urandom), 1'b0);
        end
        sent += 1 + n_follow;
      end else if (pick < 72) begin
        req = ($urandom_range(0, 2) == 0) ? REQ_PEEK : REQ_POP;
        send_word(req, LEN_W'(safe_read_len(pick_read_len())), BYTE_W'($urandom),
                  1'($urandom));
        sent++;
      end else if (pick < 86) begin
        case ($urandom_range(0, 5))
          0: send_word(REQ_SKIP, LEN_W'(used_now()), BYTE_W'($urandom), 1'($urandom));
          1: begin
            // park an empty fifo a few slots short of the wrap point
            amount = DEPTH - int'($urandom_range(1, 24));
            amount = (amount - wr_idx + DEPTH) % DEPTH;
            send_word(REQ_ADV, LEN_W'(amount), BYTE_W'($urandom), 1'($urandom));
            send_word(REQ_SKIP, LEN_W'(used_now()), BYTE_W'($urandom), 1'($urandom));
            sent++;
          end
          2: begin
            // squeeze free space down to a handful of bytes
            amount = free_now() - int'($urandom_range(0, 16));
            if (amount < 0) amount = 0;
            send_word(REQ_ADV, LEN_W'(amount), BYTE_W'($urandom), 1'($urandom));
          end
          3: send_word(REQ_ADV, LEN_W'($urandom_range(0, 15)), BYTE_W'($urandom), 1'b0);
          4: send_word(REQ_SKIP, LEN_W'($urandom_range(0, 15)), BYTE_W'($urandom), 1'b1);
          default: begin
            req = $urandom_range(0, 1) ? REQ_SKIP : REQ_ADV;
            send_word(req, LEN_W'($urandom), BYTE_W'($urandom), 1'($urandom));
          end
        endcase
        sent++;
      end else if (pick < 90) begin
        send_word(REQ_CLEAR, LEN_W'($urandom), BYTE_W'($urandom), 1'($urandom));
        sent++;
      end else begin
        req = REQ_W'($urandom_range(0, 7));
        len = $urandom_range(0, LEN_MAX);
        if (req == REQ_POP || req == REQ_PEEK) len = safe_read_len(len);
        send_word(req, LEN_W'(len), BYTE_W'($urandom), 1'($urandom));
        if (req <= REQ_CLEAR) sent++;
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_type_i     = '0;
    length_i       = '0;
    data_byte_i    = '0;
    first_of_run_i = 1'b0;
    rd_idx         = 0;
    wr_idx         = 0;
    run_rejected   = 1'b0;
    run_left       = 0;
    fail_count     = 0;
    stall_cycles   = 0;
    no_idle        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_push_runs();
    test_pop_peek();
    test_space_check();
    test_unused_codes();
    test_index_moves();
    test_random_traffic();

    @(negedge clk_i);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d pushes, %0d pops, %0d peeks, %0d skips, %0d advances, %0d clears",
             op_count[REQ_PUSH], op_count[REQ_POP], op_count[REQ_PEEK],
             op_count[REQ_SKIP], op_count[REQ_ADV], op_count[REQ_CLEAR]);
    $display("%0d result words checked; ok %0d, no space %0d, no data %0d, too long %0d",
             results_checked, status_seen[ST_OK], status_seen[ST_NO_SPACE],
             status_seen[ST_NO_DATA], status_seen[ST_TOO_LONG]);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
